>>> rtl/rbst_pkg.sv
// Package for the ring border scan-line tracker.
// Holds colour codes, region states, verdicts, register indexes and the config bundle.
// No dependencies.
`timescale 1ns / 1ps

package rbst_pkg;

    // Default coordinate width
    localparam int COORD_WIDTH = 12;

    // Field widths fixed by the interface
    localparam int HUE_WIDTH   = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CNT_WIDTH   = 9;
    localparam logic [CNT_WIDTH-1:0] CNT_MAX = '1;

    // Register reset values
    localparam logic [HUE_WIDTH-1:0] BLUE_LOW_RST   = 8'd100;
    localparam logic [HUE_WIDTH-1:0] BLUE_HIGH_RST  = 8'd180;
    localparam logic [HUE_WIDTH-1:0] RED_LOW_RST    = 8'd1;
    localparam logic [HUE_WIDTH-1:0] RED_HIGH_RST   = 8'd15;
    localparam logic [HUE_WIDTH-1:0] GREEN_LOW_RST  = 8'd80;
    localparam logic [HUE_WIDTH-1:0] GREEN_HIGH_RST = 8'd95;
    localparam logic [HUE_WIDTH-1:0] INV_LIMIT_RST  = 8'd10;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BLUE_LOW   = 3'd0,
        REG_BLUE_HIGH  = 3'd1,
        REG_RED_LOW    = 3'd2,
        REG_RED_HIGH   = 3'd3,
        REG_GREEN_LOW  = 3'd4,
        REG_GREEN_HIGH = 3'd5,
        REG_INV_LIMIT  = 3'd6
    } reg_idx_t;

    // Colour codes
    typedef enum logic [1:0] {
        CODE_BLUE  = 2'd0,
        CODE_RED   = 2'd1,
        CODE_GREEN = 2'd2,
        CODE_NONE  = 2'd3
    } code_t;

    // Region states: a colour region, or the initial region
    typedef enum logic [2:0] {
        REGION_BLUE    = 3'd0,
        REGION_RED     = 3'd1,
        REGION_GREEN   = 3'd2,
        REGION_NONE    = 3'd3,
        REGION_INITIAL = 3'd4
    } region_t;

    // Line verdicts
    typedef enum logic [1:0] {
        VERDICT_FOUND    = 2'd0,
        VERDICT_REJECT   = 2'd1,
        VERDICT_NOBORDER = 2'd2
    } verdict_t;

    // Configuration bundle
    typedef struct packed {
        logic [HUE_WIDTH-1:0] blue_low;
        logic [HUE_WIDTH-1:0] blue_high;
        logic [HUE_WIDTH-1:0] red_low;
        logic [HUE_WIDTH-1:0] red_high;
        logic [HUE_WIDTH-1:0] green_low;
        logic [HUE_WIDTH-1:0] green_high;
        logic [HUE_WIDTH-1:0] invalid_limit;
    } cfg_t;

endpackage

>>> rtl/rbst_classify.sv
// Hue classifier: maps a hue to a colour code using the configured ranges.
// Depends on rbst_pkg.
`timescale 1ns / 1ps

module rbst_classify (
    input  logic [rbst_pkg::HUE_WIDTH-1:0] hue,
    input  rbst_pkg::cfg_t                 cfg,
    output rbst_pkg::code_t                code
);

    logic is_blue;
    logic is_red;
    logic is_green;

    // Inclusive range tests; low above high gives an empty range
    assign is_blue  = (hue >= cfg.blue_low)  && (hue <= cfg.blue_high);
    assign is_red   = (hue >= cfg.red_low)   && (hue <= cfg.red_high);
    assign is_green = (hue >= cfg.green_low) && (hue <= cfg.green_high);

    // Blue wins over red, red over green
    always_comb
    begin
        priority if (is_blue)
            code = rbst_pkg::CODE_BLUE;
        else if (is_red)
            code = rbst_pkg::CODE_RED;
        else if (is_green)
            code = rbst_pkg::CODE_GREEN;
        else
            code = rbst_pkg::CODE_NONE;
    end

endmodule

>>> rtl/rbst_track.sv
// Line tracker: region state machine, border capture and verdict register.
// Depends on rbst_pkg; takes the colour code from rbst_classify.
`timescale 1ns / 1ps

module rbst_track #(
    parameter int COORD_WIDTH = rbst_pkg::COORD_WIDTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Registered pixel word
    input  logic                              item_valid,
    input  rbst_pkg::code_t                   code,
    input  logic [COORD_WIDTH-1:0]            px,
    input  logic [COORD_WIDTH-1:0]            py,
    input  logic                              start,
    input  logic                              last,
    input  logic [rbst_pkg::HUE_WIDTH-1:0]    invalid_limit,
    output logic                              advance,
    // Result channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [1:0]                        verdict,
    output logic [COORD_WIDTH-1:0]            inner_x,
    output logic [COORD_WIDTH-1:0]            inner_y,
    output logic [COORD_WIDTH-1:0]            outer_x,
    output logic [COORD_WIDTH-1:0]            outer_y
);

    localparam int CW = rbst_pkg::CNT_WIDTH;

    // Line state
    rbst_pkg::region_t        region_reg,    region_next;
    rbst_pkg::code_t          prev_reg,      prev_next;
    logic [COORD_WIDTH-1:0]   run_x_reg,     run_x_next;
    logic [COORD_WIDTH-1:0]   run_y_reg,     run_y_next;
    logic [CW-1:0]            cnt_reg,       cnt_next;
    logic [COORD_WIDTH-1:0]   inner_x_reg,   inner_x_next;
    logic [COORD_WIDTH-1:0]   inner_y_reg,   inner_y_next;
    logic [COORD_WIDTH-1:0]   outer_x_reg,   outer_x_next;
    logic [COORD_WIDTH-1:0]   outer_y_reg,   outer_y_next;
    logic                     found_reg,     found_next;
    logic                     done_reg,      done_next;

    // Result register
    logic                     out_valid_reg, out_valid_next;
    rbst_pkg::verdict_t       verdict_reg,   verdict_next;
    logic [COORD_WIDTH-1:0]   res_ix_reg,    res_ix_next;
    logic [COORD_WIDTH-1:0]   res_iy_reg,    res_iy_next;
    logic [COORD_WIDTH-1:0]   res_ox_reg,    res_ox_next;
    logic [COORD_WIDTH-1:0]   res_oy_reg,    res_oy_next;

    logic                     fire;
    logic                     emit;
    rbst_pkg::verdict_t       emit_verdict;
    rbst_pkg::region_t        code_region;
    logic [CW-1:0]            cnt_inc;

    // Take the next word whenever the result register is free or draining
    assign advance = !out_valid_reg || !out_stall;
    assign fire    = item_valid && advance;

    assign code_region = rbst_pkg::region_t'({1'b0, code});

    // Process one pixel against the line state
    always_comb
    begin
        region_next  = region_reg;
        prev_next    = prev_reg;
        run_x_next   = run_x_reg;
        run_y_next   = run_y_reg;
        cnt_next     = cnt_reg;
        inner_x_next = inner_x_reg;
        inner_y_next = inner_y_reg;
        outer_x_next = outer_x_reg;
        outer_y_next = outer_y_reg;
        found_next   = found_reg;
        done_next    = done_reg;
        emit         = 1'b0;
        emit_verdict = rbst_pkg::VERDICT_FOUND;
        cnt_inc      = '0;

        if (fire)
        begin
            // Clear the line state ahead of the first pixel
            if (start)
            begin
                region_next  = rbst_pkg::REGION_INITIAL;
                prev_next    = rbst_pkg::CODE_NONE;
                run_x_next   = '0;
                run_y_next   = '0;
                cnt_next     = '0;
                inner_x_next = '0;
                inner_y_next = '0;
                outer_x_next = '0;
                outer_y_next = '0;
                found_next   = 1'b0;
                done_next    = 1'b0;
            end

            if (!done_next)
            begin
                // Count unclassified pixels, saturating
                if (code == rbst_pkg::CODE_NONE && cnt_next != rbst_pkg::CNT_MAX)
                    cnt_inc = cnt_next + CW'(1);
                else
                    cnt_inc = cnt_next;
                cnt_next = cnt_inc;

                if (code == rbst_pkg::CODE_NONE
                    && cnt_inc > CW'(invalid_limit))
                begin
                    emit         = 1'b1;
                    emit_verdict = found_next ? rbst_pkg::VERDICT_FOUND
                                              : rbst_pkg::VERDICT_NOBORDER;
                end
                else
                begin
                    if (code != prev_next)
                    begin
                        // New run: note where it starts
                        run_x_next = px;
                        run_y_next = py;
                        prev_next  = code;
                    end
                    else if (code_region != region_next)
                    begin
                        // A confirmed pair moves the region machine
                        unique case (region_next)
                            rbst_pkg::REGION_INITIAL:
                            begin
                                if (code != rbst_pkg::CODE_BLUE)
                                begin
                                    emit         = 1'b1;
                                    emit_verdict = rbst_pkg::VERDICT_REJECT;
                                end
                                else
                                    region_next = rbst_pkg::REGION_BLUE;
                            end
                            rbst_pkg::REGION_BLUE:
                            begin
                                if (code == rbst_pkg::CODE_RED)
                                begin
                                    inner_x_next = run_x_next;
                                    inner_y_next = run_y_next;
                                    region_next  = rbst_pkg::REGION_RED;
                                end
                                else if (code == rbst_pkg::CODE_GREEN)
                                begin
                                    emit         = 1'b1;
                                    emit_verdict = rbst_pkg::VERDICT_REJECT;
                                end
                            end
                            rbst_pkg::REGION_RED:
                            begin
                                if (code == rbst_pkg::CODE_BLUE)
                                begin
                                    emit         = 1'b1;
                                    emit_verdict = rbst_pkg::VERDICT_REJECT;
                                end
                                else
                                begin
                                    outer_x_next = run_x_next;
                                    outer_y_next = run_y_next;
                                    found_next   = 1'b1;
                                    region_next  = code_region;
                                end
                            end
                            default:
                            begin
                                region_next = region_next;
                            end
                        endcase
                    end

                    // Close the line on its last pixel
                    if (!emit && last)
                    begin
                        emit         = 1'b1;
                        emit_verdict = found_next ? rbst_pkg::VERDICT_FOUND
                                                  : rbst_pkg::VERDICT_NOBORDER;
                    end
                end

                if (emit)
                    done_next = 1'b1;
            end
        end
    end

    // Load or drain the result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        verdict_next   = verdict_reg;
        res_ix_next    = res_ix_reg;
        res_iy_next    = res_iy_reg;
        res_ox_next    = res_ox_reg;
        res_oy_next    = res_oy_reg;
        if (advance)
        begin
            out_valid_next = emit;
            if (emit)
            begin
                verdict_next = emit_verdict;
                res_ix_next  = inner_x_next;
                res_iy_next  = inner_y_next;
                res_ox_next  = outer_x_next;
                res_oy_next  = outer_y_next;
            end
        end
    end

    // State registers; reset acts as the start of a line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_reg    <= rbst_pkg::REGION_INITIAL;
            prev_reg      <= rbst_pkg::CODE_NONE;
            run_x_reg     <= '0;
            run_y_reg     <= '0;
            cnt_reg       <= '0;
            inner_x_reg   <= '0;
            inner_y_reg   <= '0;
            outer_x_reg   <= '0;
            outer_y_reg   <= '0;
            found_reg     <= 1'b0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            region_reg    <= region_next;
            prev_reg      <= prev_next;
            run_x_reg     <= run_x_next;
            run_y_reg     <= run_y_next;
            cnt_reg       <= cnt_next;
            inner_x_reg   <= inner_x_next;
            inner_y_reg   <= inner_y_next;
            outer_x_reg   <= outer_x_next;
            outer_y_reg   <= outer_y_next;
            found_reg     <= found_next;
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload, no reset needed
    always_ff @(posedge clk)
    begin
        verdict_reg <= verdict_next;
        res_ix_reg  <= res_ix_next;
        res_iy_reg  <= res_iy_next;
        res_ox_reg  <= res_ox_next;
        res_oy_reg  <= res_oy_next;
    end

    assign out_valid = out_valid_reg;
    assign verdict   = verdict_reg;
    assign inner_x   = res_ix_reg;
    assign inner_y   = res_iy_reg;
    assign outer_x   = res_ox_reg;
    assign outer_y   = res_oy_reg;

endmodule

>>> rtl/ring_border_scanline_tracker_unit.sv
// Top level of the ring border scan-line tracker: config registers, pixel input
// register, hue classifier and line tracker. Depends on rbst_pkg, rbst_classify, rbst_track.
`timescale 1ns / 1ps

//  Channel   Direction  Handshake              Word
//  --------  ---------  ---------------------  ---------------------------------------
//  pixel     in         in_valid / in_stall    hue, pix_x, pix_y, line_start, line_end
//  result    out        out_valid / out_stall  verdict, inner_x, inner_y, outer_x, outer_y
//  config    in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  One pixel word is taken every cycle while in_stall is low; a verdict leaves through
//  the input register and then the result register, around one pass of logic.
//  Reset clears all line state as a line start and restores the register defaults.
//  A stall on a waiting result holds the result register and the input register together,
//  and in_stall rises while that register holds a word; config writes are always taken.

module ring_border_scanline_tracker_unit #(
    parameter int COORD_WIDTH = rbst_pkg::COORD_WIDTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Pixel channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [rbst_pkg::HUE_WIDTH-1:0]      hue,
    input  logic [COORD_WIDTH-1:0]              pix_x,
    input  logic [COORD_WIDTH-1:0]              pix_y,
    input  logic                                line_start,
    input  logic                                line_end,
    // Result channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [1:0]                          verdict,
    output logic [COORD_WIDTH-1:0]              inner_x,
    output logic [COORD_WIDTH-1:0]              inner_y,
    output logic [COORD_WIDTH-1:0]              outer_x,
    output logic [COORD_WIDTH-1:0]              outer_y,
    // Config channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rbst_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rbst_pkg::HUE_WIDTH-1:0]      cfg_data
);

    rbst_pkg::cfg_t                    cfg_reg, cfg_next;

    logic                              in_valid_reg, in_valid_next;
    logic [rbst_pkg::HUE_WIDTH-1:0]    hue_reg;
    logic [COORD_WIDTH-1:0]            px_reg;
    logic [COORD_WIDTH-1:0]            py_reg;
    logic                              start_reg;
    logic                              last_reg;

    logic                              in_fire;
    logic                              advance;
    rbst_pkg::code_t                   code;

    // Config writes are taken at any time
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                rbst_pkg::REG_BLUE_LOW:   cfg_next.blue_low      = cfg_data;
                rbst_pkg::REG_BLUE_HIGH:  cfg_next.blue_high     = cfg_data;
                rbst_pkg::REG_RED_LOW:    cfg_next.red_low       = cfg_data;
                rbst_pkg::REG_RED_HIGH:   cfg_next.red_high      = cfg_data;
                rbst_pkg::REG_GREEN_LOW:  cfg_next.green_low     = cfg_data;
                rbst_pkg::REG_GREEN_HIGH: cfg_next.green_high    = cfg_data;
                rbst_pkg::REG_INV_LIMIT:  cfg_next.invalid_limit = cfg_data;
                default:                  cfg_next               = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.blue_low      <= rbst_pkg::BLUE_LOW_RST;
            cfg_reg.blue_high     <= rbst_pkg::BLUE_HIGH_RST;
            cfg_reg.red_low       <= rbst_pkg::RED_LOW_RST;
            cfg_reg.red_high      <= rbst_pkg::RED_HIGH_RST;
            cfg_reg.green_low     <= rbst_pkg::GREEN_LOW_RST;
            cfg_reg.green_high    <= rbst_pkg::GREEN_HIGH_RST;
            cfg_reg.invalid_limit <= rbst_pkg::INV_LIMIT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Hold the pixel word while the tracker cannot take it
    assign in_stall      = in_valid_reg && !advance;
    assign in_fire       = in_valid && !in_stall;
    assign in_valid_next = in_fire ? 1'b1 : (advance ? 1'b0 : in_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            hue_reg   <= hue;
            px_reg    <= pix_x;
            py_reg    <= pix_y;
            start_reg <= line_start;
            last_reg  <= line_end;
        end
    end

    // Classify the registered hue
    rbst_classify u_classify (
        .hue  (hue_reg),
        .cfg  (cfg_reg),
        .code (code)
    );

    // Advance the line state and produce verdicts
    rbst_track #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_track (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (in_valid_reg),
        .code          (code),
        .px            (px_reg),
        .py            (py_reg),
        .start         (start_reg),
        .last          (last_reg),
        .invalid_limit (cfg_reg.invalid_limit),
        .advance       (advance),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .verdict       (verdict),
        .inner_x       (inner_x),
        .inner_y       (inner_y),
        .outer_x       (outer_x),
        .outer_y       (outer_y)
    );

endmodule

>>> sim/rbst_line_checker.sv
// Line verdict checker for the ring border scan-line tracker: follows the config,
// pixel and result channels, predicts each line verdict and compares it with the block.
// Depends on rbst_pkg.
`timescale 1ns / 1ps

module rbst_line_checker
    import rbst_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_stall,
    input  logic [HUE_WIDTH-1:0]   hue,
    input  logic [COORD_WIDTH-1:0] pix_x,
    input  logic [COORD_WIDTH-1:0] pix_y,
    input  logic                   line_start,
    input  logic                   line_end,
    input  logic                   out_valid,
    input  logic                   out_stall,
    input  logic [1:0]             verdict,
    input  logic [COORD_WIDTH-1:0] inner_x,
    input  logic [COORD_WIDTH-1:0] inner_y,
    input  logic [COORD_WIDTH-1:0] outer_x,
    input  logic [COORD_WIDTH-1:0] outer_y,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [HUE_WIDTH-1:0]   cfg_data,
    output int                     mismatches,
    output int                     pending
);

    typedef struct packed {
        verdict_t               kind;
        logic [COORD_WIDTH-1:0] inner_col;
        logic [COORD_WIDTH-1:0] inner_row;
        logic [COORD_WIDTH-1:0] outer_col;
        logic [COORD_WIDTH-1:0] outer_row;
    } line_verdict_t;

    // Own copy of the thresholds and of the line state
    cfg_t                   thresholds;
    region_t                region;
    code_t                  prev_code;
    logic [COORD_WIDTH-1:0] run_col, run_row;
    logic [COORD_WIDTH-1:0] inner_col, inner_row, outer_col, outer_row;
    logic [CNT_WIDTH-1:0]   none_count;
    logic                   borders_seen;
    logic                   line_closed;

    line_verdict_t verdicts_due [$];

    function automatic void clear_line();
        region       = REGION_INITIAL;
        prev_code    = CODE_NONE;
        run_col      = '0;
        run_row      = '0;
        inner_col    = '0;
        inner_row    = '0;
        outer_col    = '0;
        outer_row    = '0;
        none_count   = '0;
        borders_seen = 1'b0;
        line_closed  = 1'b0;
    endfunction

    // Blue wins over red, red over green; an empty range never matches
    function automatic code_t hue_class(logic [HUE_WIDTH-1:0] h);
        if (h >= thresholds.blue_low && h <= thresholds.blue_high)
            return CODE_BLUE;
        if (h >= thresholds.red_low && h <= thresholds.red_high)
            return CODE_RED;
        if (h >= thresholds.green_low && h <= thresholds.green_high)
            return CODE_GREEN;
        return CODE_NONE;
    endfunction

    function automatic bit close_line(verdict_t kind, output line_verdict_t res);
        line_closed   = 1'b1;
        res.kind      = kind;
        res.inner_col = inner_col;
        res.inner_row = inner_row;
        res.outer_col = outer_col;
        res.outer_row = outer_row;
        return 1'b1;
    endfunction

    // Advance the line state by one pixel; return 1 when the line gets its verdict
    function automatic bit trace_pixel(logic [HUE_WIDTH-1:0] h,
                                       logic [COORD_WIDTH-1:0] col, row,
                                       logic first, last,
                                       output line_verdict_t res);
        code_t code;
        res  = '0;
        code = hue_class(h);
        if (first)
            clear_line();
        if (line_closed)
            return 1'b0;

        // End the line early once too many unclassified pixels are seen
        if (code == CODE_NONE)
        begin
            if (none_count != CNT_MAX)
                none_count++;
            if (none_count > thresholds.invalid_limit)
                return close_line(borders_seen ? VERDICT_FOUND : VERDICT_NOBORDER, res);
        end

        if (code != prev_code)
        begin
            run_col   = col;
            run_row   = row;
            prev_code = code;
        end
        else if (region_t'(code) != region)
        begin
            case (region)
                REGION_INITIAL:
                begin
                    if (code != CODE_BLUE)
                        return close_line(VERDICT_REJECT, res);
                    region = REGION_BLUE;
                end
                REGION_BLUE:
                begin
                    if (code == CODE_RED)
                    begin
                        inner_col = run_col;
                        inner_row = run_row;
                        region    = REGION_RED;
                    end
                    else if (code == CODE_GREEN)
                        return close_line(VERDICT_REJECT, res);
                end
                REGION_RED:
                begin
                    if (code == CODE_BLUE)
                        return close_line(VERDICT_REJECT, res);
                    outer_col    = run_col;
                    outer_row    = run_row;
                    borders_seen = 1'b1;
                    region       = region_t'(code);
                end
                default: ;
            endcase
        end

        if (last)
            return close_line(borders_seen ? VERDICT_FOUND : VERDICT_NOBORDER, res);
        return 1'b0;
    endfunction

    function automatic void compare_field(string field, int unsigned want, int unsigned got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        line_verdict_t due;
        line_verdict_t fresh;
        if (!rst_n)
        begin
            thresholds = {BLUE_LOW_RST, BLUE_HIGH_RST, RED_LOW_RST, RED_HIGH_RST,
                          GREEN_LOW_RST, GREEN_HIGH_RST, INV_LIMIT_RST};
            clear_line();
            verdicts_due.delete();
            mismatches = 0;
            pending    = 0;
        end
        else
        begin
            // Follow register writes
            if (cfg_valid && cfg_ready)
            begin
                case (reg_idx_t'(cfg_index))
                    REG_BLUE_LOW:   thresholds.blue_low      = cfg_data;
                    REG_BLUE_HIGH:  thresholds.blue_high     = cfg_data;
                    REG_RED_LOW:    thresholds.red_low       = cfg_data;
                    REG_RED_HIGH:   thresholds.red_high      = cfg_data;
                    REG_GREEN_LOW:  thresholds.green_low     = cfg_data;
                    REG_GREEN_HIGH: thresholds.green_high    = cfg_data;
                    REG_INV_LIMIT:  thresholds.invalid_limit = cfg_data;
                    default: ;
                endcase
            end

            // Compare an accepted result word with the oldest verdict due
            if (out_valid && !out_stall)
            begin
                if (verdicts_due.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: verdict expected none actual %0d inner %0d,%0d outer %0d,%0d",
                             $time, verdict, inner_x, inner_y, outer_x, outer_y);
                end
                else
                begin
                    due = verdicts_due.pop_front();
                    compare_field("verdict", 32'(due.kind), 32'(verdict));
                    compare_field("inner_x", 32'(due.inner_col), 32'(inner_x));
                    compare_field("inner_y", 32'(due.inner_row), 32'(inner_y));
                    compare_field("outer_x", 32'(due.outer_col), 32'(outer_x));
                    compare_field("outer_y", 32'(due.outer_row), 32'(outer_y));
                end
            end

            // Predict from each accepted pixel word
            if (in_valid && !in_stall)
            begin
                if (trace_pixel(hue, pix_x, pix_y, line_start, line_end, fresh))
                    verdicts_due.push_back(fresh);
            end

            pending = verdicts_due.size();
        end
    end

endmodule

>>> sim/tb.sv
// Testbench top for the ring border scan-line tracker: clock, reset, config writes,
// pixel lines and result-side stalls, with the verdict taken from rbst_line_checker.
// Depends on rbst_pkg, rbst_line_checker and ring_border_scanline_tracker_unit.
`timescale 1ns / 1ps

module tb;
    import rbst_pkg::*;

    localparam int PIXEL_TARGET = 1170;
    localparam int HOLD_CYCLES  = 64;
    localparam int DRAIN_CYCLES = 10;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic [HUE_WIDTH-1:0]   hue;
    logic [COORD_WIDTH-1:0] pix_x;
    logic [COORD_WIDTH-1:0] pix_y;
    logic                   line_start;
    logic                   line_end;
    logic                   out_valid;
    logic                   out_stall;
    logic [1:0]             verdict;
    logic [COORD_WIDTH-1:0] inner_x, inner_y, outer_x, outer_y;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [HUE_WIDTH-1:0]   cfg_data;

    int   mismatches;
    int   pending;
    int   pixels_sent  = 0;
    int   src_idle_pct = 0;
    int   dst_idle_pct = 0;
    bit   hold_req     = 1'b0;
    cfg_t cur_cfg;

    ring_border_scanline_tracker_unit u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .hue        (hue),
        .pix_x      (pix_x),
        .pix_y      (pix_y),
        .line_start (line_start),
        .line_end   (line_end),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .verdict    (verdict),
        .inner_x    (inner_x),
        .inner_y    (inner_y),
        .outer_x    (outer_x),
        .outer_y    (outer_y),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    rbst_line_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .hue        (hue),
        .pix_x      (pix_x),
        .pix_y      (pix_y),
        .line_start (line_start),
        .line_end   (line_end),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .verdict    (verdict),
        .inner_x    (inner_x),
        .inner_y    (inner_y),
        .outer_x    (outer_x),
        .outer_y    (outer_y),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Hard stop
    initial
    begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Result side: random stalls, or one long hold-off when asked
    initial
    begin
        bit hold_taken;
        hold_taken = 1'b0;
        out_stall  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                out_stall <= ($urandom_range(0, 99) < dst_idle_pct);
        end
    end

    // Offer one pixel word, idling first at random, and hold it until taken
    task automatic send_pixel(logic [HUE_WIDTH-1:0] h, logic [COORD_WIDTH-1:0] col, row,
                              bit first, bit last);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        hue        <= h;
        pix_x      <= col;
        pix_y      <= row;
        line_start <= first;
        line_end   <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pixels_sent++;
    endtask

    // Stop offering, wait for every verdict due, then let the pipeline drain
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [HUE_WIDTH-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic load_thresholds(cfg_t c);
        write_reg(REG_BLUE_LOW, c.blue_low);
        write_reg(REG_BLUE_HIGH, c.blue_high);
        write_reg(REG_RED_LOW, c.red_low);
        write_reg(REG_RED_HIGH, c.red_high);
        write_reg(REG_GREEN_LOW, c.green_low);
        write_reg(REG_GREEN_HIGH, c.green_high);
        write_reg(REG_INV_LIMIT, c.invalid_limit);
        cfg_valid <= 1'b0;
        cur_cfg = c;
    endtask

    function automatic cfg_t threshold_preset(int k);
        cfg_t c;
        case (k)
            0: c = {BLUE_LOW_RST, BLUE_HIGH_RST, RED_LOW_RST, RED_HIGH_RST,
                    GREEN_LOW_RST, GREEN_HIGH_RST, INV_LIMIT_RST};
            1: c = {8'd200, 8'd255, 8'd0, 8'd30, 8'd40, 8'd60, 8'd255};
            2: c = {8'd0, 8'd63, 8'd128, 8'd191, 8'd64, 8'd127, 8'd0};
            // overlapping ranges: blue and red share hues
            3: c = {8'd120, 8'd130, 8'd110, 8'd140, 8'd100, 8'd150, 8'd3};
            4:
            begin
                c.blue_low      = HUE_WIDTH'($urandom_range(0, 200));
                c.blue_high     = c.blue_low + HUE_WIDTH'($urandom_range(0, 55));
                c.red_low       = HUE_WIDTH'($urandom_range(0, 200));
                c.red_high      = c.red_low + HUE_WIDTH'($urandom_range(0, 55));
                c.green_low     = HUE_WIDTH'($urandom_range(0, 200));
                c.green_high    = c.green_low + HUE_WIDTH'($urandom_range(0, 55));
                c.invalid_limit = HUE_WIDTH'($urandom_range(0, 255));
            end
            // empty blue range: no line can find a border
            default: c = {8'd255, 8'd0, 8'd20, 8'd60, 8'd0, 8'd255, 8'd5};
        endcase
        return c;
    endfunction

    // Pick a hue of the wanted colour under the current thresholds
    function automatic logic [HUE_WIDTH-1:0] pick_hue(code_t cls);
        logic [HUE_WIDTH-1:0] lo, hi, h;
        case (cls)
            CODE_BLUE:
            begin
                lo = cur_cfg.blue_low;
                hi = cur_cfg.blue_high;
            end
            CODE_RED:
            begin
                lo = cur_cfg.red_low;
                hi = cur_cfg.red_high;
            end
            CODE_GREEN:
            begin
                lo = cur_cfg.green_low;
                hi = cur_cfg.green_high;
            end
            default:
            begin
                h = HUE_WIDTH'($urandom_range(0, 255));
                for (int t = 0; t < 8; t++)
                    if ((h >= cur_cfg.blue_low && h <= cur_cfg.blue_high) ||
                        (h >= cur_cfg.red_low && h <= cur_cfg.red_high) ||
                        (h >= cur_cfg.green_low && h <= cur_cfg.green_high))
                        h = HUE_WIDTH'($urandom_range(0, 255));
                return h;
            end
        endcase
        if (lo > hi)
            return HUE_WIDTH'($urandom_range(0, 255));
        return HUE_WIDTH'($urandom_range(lo, hi));
    endfunction

    // One scan line: blue, red, then green or none with random runs and noise,
    // or a loose mix of runs
    task automatic send_line(bit shaped);
        code_t                  cls [$];
        int                     len [$];
        int                     n_runs;
        int                     total;
        int                     k;
        bit                     first_flag, end_flag;
        logic [COORD_WIDTH-1:0] col, row;
        if (shaped)
        begin
            cls.push_back(CODE_BLUE);
            len.push_back($urandom_range(2, 4));
            if ($urandom_range(0, 4) == 0)
            begin
                cls.push_back(CODE_NONE);
                len.push_back(1);
            end
            cls.push_back(CODE_RED);
            len.push_back($urandom_range(2, 4));
            if ($urandom_range(0, 6) != 0)
            begin
                cls.push_back($urandom_range(0, 1) ? CODE_GREEN : CODE_NONE);
                len.push_back($urandom_range(2, 4));
            end
            n_runs = $urandom_range(0, 3);
        end
        else
            n_runs = $urandom_range(2, 6);
        for (int r = 0; r < n_runs; r++)
        begin
            cls.push_back(code_t'($urandom_range(0, 3)));
            len.push_back(($urandom_range(0, 9) == 0) ? $urandom_range(1, 14)
                                                      : $urandom_range(1, 3));
        end

        total = 0;
        foreach (len[i])
            total += len[i];
        col = COORD_WIDTH'($urandom);
        row = COORD_WIDTH'($urandom);
        if ($urandom_range(0, 9) == 0)
            row = $urandom_range(0, 1) ? '1 : '0;
        first_flag = ($urandom_range(0, 19) != 0);
        end_flag   = ($urandom_range(0, 7) != 0);
        k = 0;
        foreach (cls[r])
            for (int p = 0; p < len[r]; p++)
            begin
                k++;
                send_pixel(pick_hue(cls[r]), col, row, first_flag && k == 1,
                           end_flag && k == total);
                col = col + COORD_WIDTH'(($urandom_range(0, 15) == 0)
                                         ? $urandom_range(2, 40) : 1);
            end
    endtask

    initial
    begin
        int seg;
        int seg_end;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        hue        = '0;
        pix_x      = '0;
        pix_y      = '0;
        line_start = 1'b0;
        line_end   = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = REG_BLUE_LOW;
        cfg_data   = '0;
        cur_cfg    = threshold_preset(0);
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        src_idle_pct = 26;
        dst_idle_pct = 56;

        // Full ring across the column wrap: inner at first red, outer at first green
        send_pixel(8'd100, 12'd4094, 12'd4095, 1'b1, 1'b0);
        send_pixel(8'd180, 12'd4095, 12'd4095, 1'b0, 1'b0);
        send_pixel(8'd1,   12'd0,    12'd4095, 1'b0, 1'b0);
        send_pixel(8'd15,  12'd1,    12'd4095, 1'b0, 1'b0);
        send_pixel(8'd80,  12'd2,    12'd4095, 1'b0, 1'b0);
        send_pixel(8'd95,  12'd3,    12'd4095, 1'b0, 1'b1);
        // One-pixel line of an unclassified hue: rejected at once
        send_pixel(8'd255, 12'd4095, 12'd0, 1'b1, 1'b1);
        // Red pair before any blue; the trailing pixel is dropped
        send_pixel(8'd1,   12'd10, 12'd0, 1'b1, 1'b0);
        send_pixel(8'd15,  12'd11, 12'd0, 1'b0, 1'b0);
        send_pixel(8'd100, 12'd12, 12'd0, 1'b0, 1'b0);
        // Green straight after blue
        send_pixel(8'd100, 12'd20, 12'd7, 1'b1, 1'b0);
        send_pixel(8'd180, 12'd21, 12'd7, 1'b0, 1'b0);
        send_pixel(8'd80,  12'd22, 12'd7, 1'b0, 1'b0);
        send_pixel(8'd95,  12'd23, 12'd7, 1'b0, 1'b0);
        // Blue back after red
        send_pixel(8'd100, 12'd30, 12'd8, 1'b1, 1'b0);
        send_pixel(8'd100, 12'd31, 12'd8, 1'b0, 1'b0);
        send_pixel(8'd1,   12'd32, 12'd8, 1'b0, 1'b0);
        send_pixel(8'd1,   12'd33, 12'd8, 1'b0, 1'b0);
        send_pixel(8'd180, 12'd34, 12'd8, 1'b0, 1'b0);
        send_pixel(8'd180, 12'd35, 12'd8, 1'b0, 1'b0);
        // Unclassified pair inside blue is passed over; line ends with no outer border
        send_pixel(8'd120, 12'd40, 12'd9, 1'b1, 1'b0);
        send_pixel(8'd120, 12'd41, 12'd9, 1'b0, 1'b0);
        send_pixel(8'd0,   12'd42, 12'd9, 1'b0, 1'b0);
        send_pixel(8'd255, 12'd43, 12'd9, 1'b0, 1'b0);
        send_pixel(8'd3,   12'd44, 12'd9, 1'b0, 1'b0);
        send_pixel(8'd3,   12'd45, 12'd9, 1'b0, 1'b0);
        send_pixel(8'd99,  12'd46, 12'd9, 1'b0, 1'b1);

        // Random lines, a new threshold set for each segment
        seg = 0;
        while (pixels_sent < PIXEL_TARGET)
        begin
            wait_idle();
            load_thresholds(threshold_preset(seg % 6));
            if (pixels_sent < 400)
            begin
                src_idle_pct = 26;
                dst_idle_pct = 56;
            end
            else if (pixels_sent < 800)
            begin
                src_idle_pct = 56;
                dst_idle_pct = 26;
            end
            else
            begin
                src_idle_pct = 0;
                dst_idle_pct = 0;
            end
            if (seg == 1)
                hold_req = 1'b1;
            seg_end = pixels_sent + ((seg % 6 == 5) ? 40 : 100);
            while (pixels_sent < seg_end && pixels_sent < PIXEL_TARGET)
                send_line($urandom_range(0, 99) < 75);
            seg++;
        end

        wait_idle();
        if (mismatches == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> files.f
rtl/rbst_pkg.sv
rtl/rbst_classify.sv
rtl/rbst_track.sv
rtl/ring_border_scanline_tracker_unit.sv
sim/rbst_line_checker.sv
sim/tb.sv
